// File: rtl/budgeted_xorshift_sampler_core_macros.svh
// Assertion macros used by the checker file.
`ifndef BUDGETED_XORSHIFT_SAMPLER_CORE_MACROS_SVH
`define BUDGETED_XORSHIFT_SAMPLER_CORE_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define BXS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that an implication holds at the clock edge after the antecedent.
`define BXS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bxs_pkg.sv
// ----------------------------------------------------------------------------
// bxs_pkg
// Constants, types and helper functions for the xorshift64* sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package bxs_pkg;

  localparam logic [63:0] SEED_INIT    = 64'h1234_5678_90AB_CDEF;
  localparam logic [63:0] STAR_MULT    = 64'h2545_F491_4F6C_DD1D;
  localparam logic [31:0] BUDGET_RESET = 32'hFFFF_FFFF;

  localparam logic [0:0] REG_SEED   = 1'b0;
  localparam logic [0:0] REG_BUDGET = 1'b1;
  localparam int         CFG_IDX_W  = 1;

  localparam logic ACT_INT = 1'b0;
  localparam logic ACT_DBL = 1'b1;

  // One xorshift64 step: shift right 12, left 25, right 27.
  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage
`default_nettype wire

// File: rtl/budgeted_xorshift_sampler_core.sv
// ----------------------------------------------------------------------------
// budgeted_xorshift_sampler_core
// Budgeted xorshift64* sampler: random 32-bit integer or unit double per
// request, or the caller's value passed through once the budget runs out.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------
//  request   | in_valid / in_stall  | action, original
//  result    | out_valid / out_stall| result, from_generator
//  config    | cfg_we               | cfg_idx, cfg_data
//
// One request per cycle is sustained while the result end does not stall.
// The state update (xor-shifts) and budget check finish in the accept cycle;
// the multiply takes two stages and the double pack two more.
// Reset loads the default seed and an unlimited budget.
// The pipeline advances as a whole; a stall at the result end holds it and
// raises in_stall only while the last stage holds an unaccepted result.
// ----------------------------------------------------------------------------
`default_nettype none
module budgeted_xorshift_sampler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [63:0] original,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] result,
  output logic             from_generator,
  input  wire logic        cfg_we,
  input  wire logic [bxs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [63:0] cfg_data
);
  localparam int DEPTH = 5;

  logic [63:0] gen_state;
  logic [31:0] remaining;
  logic        adv;
  logic        take;
  logic        draw;

  // Pipeline side bands, one slot per stage.
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] act;
  logic [DEPTH-1:0] gen;
  logic [63:0]      orig [DEPTH];
  logic [63:0]      mul_in;
  logic [63:0]      prod;
  logic [63:0]      dbl;
  logic [63:0]      xs_next;
  logic [31:0]      int_mid;
  logic [31:0]      int_out;

  // Advance the whole pipe unless the output holds a result not yet taken.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign take     = in_valid && adv;
  assign draw     = remaining[31] || (remaining != 32'd0);
  assign xs_next  = bxs_pkg::xs_step(gen_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= bxs_pkg::SEED_INIT;
      remaining <= bxs_pkg::BUDGET_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == bxs_pkg::REG_SEED) begin
        gen_state <= (cfg_data == 64'd0) ? bxs_pkg::SEED_INIT : cfg_data;
      end else begin
        remaining <= cfg_data[31:0];
      end
    end else if (take && draw) begin
      gen_state <= xs_next;
      if (!remaining[31]) remaining <= remaining - 32'd1;
    end
  end

  // Stage 0 registers the new state for the multiplier.
  always_ff @(posedge clk) begin
    if (adv) mul_in <= xs_next;
  end

  // Arithmetic stages hold with the side band on a stall.
  bxs_mul64 u_mul (.clk(clk), .en(adv), .a(mul_in), .p(prod));
  bxs_pack  u_pack (.clk(clk), .en(adv), .m(prod[63:11]), .bits(dbl));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act  <= {act[DEPTH-2:0], action};
      gen  <= {gen[DEPTH-2:0], draw};
      orig[0] <= original;
      for (int i = 1; i < DEPTH; i++) orig[i] <= orig[i-1];
    end
  end

  // Carry the integer sample alongside the two pack stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      int_mid <= prod[63:32];
      int_out <= int_mid;
    end
  end

  assign out_valid      = vld[DEPTH-1];
  assign from_generator = gen[DEPTH-1];
  always_comb begin
    if (!gen[DEPTH-1]) begin
      result = (act[DEPTH-1] == bxs_pkg::ACT_DBL) ? orig[DEPTH-1]
             : {32'd0, orig[DEPTH-1][31:0]};
    end else if (act[DEPTH-1] == bxs_pkg::ACT_DBL) begin
      result = dbl;
    end else begin
      result = {32'd0, int_out};
    end
  end
endmodule
`default_nettype wire

// File: rtl/bxs_mul64.sv
// ----------------------------------------------------------------------------
// bxs_mul64
// Low 64 bits of state times the output constant, as three 32x32 partial
// products over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module bxs_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  output logic      [63:0] p
);
  localparam logic [31:0] ML = bxs_pkg::STAR_MULT[31:0];
  localparam logic [31:0] MH = bxs_pkg::STAR_MULT[63:32];

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // Stage one: partial products; only the low half of the cross terms matters.
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0]) * 64'(ML);
      lh <= 32'(a[31:0] * MH);
      hl <= 32'(a[63:32] * ML);
    end
  end

  // Stage two: sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ll + {lh + hl, 32'd0};
    end
  end
endmodule
`default_nettype wire

// File: rtl/bxs_pack.sv
// ----------------------------------------------------------------------------
// bxs_pack
// Exact double bits of m / 2^53 for a 53-bit m: priority encode, then
// normalize through a registered stage.
// ----------------------------------------------------------------------------
`default_nettype none
module bxs_pack (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [52:0] m,
  output logic      [63:0] bits
);
  logic [5:0]  top;
  logic [5:0]  top_q;
  logic [52:0] m_q;
  logic        zero_q;
  logic [52:0] norm;

  // Find the leading one.
  always_comb begin
    top = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) top = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_q  <= top;
      m_q    <= m;
      zero_q <= (m == 53'd0);
    end
  end

  assign norm = m_q << (6'd52 - top_q);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_q) begin
        bits <= 64'd0;
      end else begin
        bits <= {1'b0, 11'(11'd970 + 11'(top_q)), norm[51:0]};
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/bxs_checker.sv
// ----------------------------------------------------------------------------
// bxs_port_props
// Port-level checks for the sampler core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "budgeted_xorshift_sampler_core_macros.svh"
module bxs_port_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] result,
  input wire logic        from_generator
);
  `BXS_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `BXS_ASSERT_IMPL(a_stall_src, clk, rst, in_stall, out_valid && out_stall, "spurious stall")
  `BXS_ASSERT_IMPL(a_int_high, clk, rst, out_valid && from_generator && result[63:32] != 32'd0, result[63:62] == 2'b00, "bad double")
endmodule
bind budgeted_xorshift_sampler_core bxs_port_props u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .result(result), .from_generator(from_generator)
);
`default_nettype wire
